// File: sv/sase_pkg.sv
// Shared constants and types for the sorted array search engine.
package sase_pkg;

    localparam int DEPTH   = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 6;
    localparam int FUNC_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_BINARY = 2'd1,
        FUNC_LINEAR = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // binary search bounds: low up to DEPTH, high down to -1, plus headroom for the sum
    typedef logic signed [CNT_W+1:0] t_bound;

endpackage

// File: sv/sase_ram.sv
// Generic single-port RAM with registered read.
module sase_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sorted_array_search_engine_top.sv
// Sorted array search engine: element store with binary and linear search.
//
// The element store is one single-port RAM of DEPTH signed 32-bit words with a
// registered read; array_size (saturated to DEPTH) sets how many leading entries
// a search covers. A write request (func 0) gives no result. A binary search
// (func 1) handles each probe as an address step, then a compare on the read
// data. A linear search (func 2) reads one entry per cycle from the RAM port.
// Func 3 requests are taken and dropped. One request is in work at a time; a
// finished result sits in an output register, and the next request is taken
// while it waits there. Entries must be written before a search reads them.
module sorted_array_search_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [sase_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [sase_pkg::FUNC_W-1:0]  i_func,
    input  logic [sase_pkg::ADDR_W-1:0]  i_elem_index,
    input  logic signed [sase_pkg::DATA_W-1:0] i_data_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [sase_pkg::ADDR_W-1:0]  o_match_index,
    output logic [sase_pkg::CNT_W-1:0]   o_match_count
);

    import sase_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIN_ADDR,
        S_BIN_CMP,
        S_LIN,
        S_LIN_TAIL,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [SIZE_W-1:0]   r_cfg_size;
    logic signed [DATA_W-1:0] r_key;
    t_bound              r_low;
    t_bound              r_high;
    logic [ADDR_W-1:0]   r_mid;
    logic [ADDR_W-1:0]   r_idx;
    logic                r_cmp_valid;
    logic [ADDR_W-1:0]   r_cmp_idx;
    logic                r_found;
    logic [ADDR_W-1:0]   r_where;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;
    logic                r_out_found;
    logic [ADDR_W-1:0]   r_out_where;
    logic [CNT_W-1:0]    r_out_count;

    logic [CNT_W-1:0]    n_size;
    t_bound              n_mid;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [DATA_W-1:0]   ram_rdata;
    logic signed [DATA_W-1:0] rd_word;
    logic                in_accept;
    logic                out_free;
    logic                lin_hit;

    assign n_size = (r_cfg_size > SIZE_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                  : r_cfg_size[CNT_W-1:0];
    assign n_mid     = (r_low + r_high) >>> 1;
    assign rd_word   = $signed(ram_rdata);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign lin_hit   = r_cmp_valid && (rd_word == r_key);

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = i_elem_index;
        unique case (r_state)
            S_IDLE: begin
                ram_we   = i_in_valid && (t_func'(i_func) == FUNC_WRITE);
                ram_addr = i_elem_index;
            end
            S_BIN_ADDR: ram_addr = n_mid[ADDR_W-1:0];
            S_LIN:      ram_addr = r_idx;
            default:    ram_addr = i_elem_index;
        endcase
    end

    sase_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_data_value),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_size  <= '0;
            r_out_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_size <= i_cfg_wr_data;
            end
            // S_FINISH refills the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_key   <= i_data_value;
                        r_found <= 1'b0;
                        r_where <= '0;
                        r_count <= '0;
                        r_low   <= '0;
                        r_high  <= t_bound'(n_size) - t_bound'(1);
                        r_idx   <= '0;
                        r_cmp_valid <= 1'b0;
                        unique case (t_func'(i_func))
                            FUNC_BINARY: r_state <= S_BIN_ADDR;
                            FUNC_LINEAR: r_state <= (n_size == '0) ? S_FINISH : S_LIN;
                            default:     r_state <= S_IDLE;
                        endcase
                    end
                end
                S_BIN_ADDR: begin
                    if (r_low > r_high) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_mid   <= n_mid[ADDR_W-1:0];
                        r_state <= S_BIN_CMP;
                    end
                end
                S_BIN_CMP: begin
                    if (rd_word == r_key) begin
                        r_found <= 1'b1;
                        r_where <= r_mid;
                        r_count <= CNT_W'(1);
                        r_state <= S_FINISH;
                    end else begin
                        if (r_key < rd_word) begin
                            r_high <= t_bound'({1'b0, r_mid}) - t_bound'(1);
                        end else begin
                            r_low <= t_bound'({1'b0, r_mid}) + t_bound'(1);
                        end
                        r_state <= S_BIN_ADDR;
                    end
                end
                S_LIN: begin
                    // compare the word read last cycle while the next read goes out
                    if (lin_hit) begin
                        r_count <= r_count + CNT_W'(1);
                        r_where <= r_cmp_idx;
                    end
                    r_cmp_valid <= 1'b1;
                    r_cmp_idx   <= r_idx;
                    if ({1'b0, r_idx} == n_size - CNT_W'(1)) begin
                        r_state <= S_LIN_TAIL;
                    end else begin
                        r_idx <= r_idx + ADDR_W'(1);
                    end
                end
                S_LIN_TAIL: begin
                    r_cmp_valid <= 1'b0;
                    if (lin_hit) begin
                        r_count <= r_count + CNT_W'(1);
                        r_where <= r_cmp_idx;
                        r_found <= 1'b1;
                    end else begin
                        r_found <= (r_count != '0);
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found;
                        r_out_where <= r_where;
                        r_out_count <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_match_index = r_out_where;
    assign o_match_count = r_out_count;

endmodule

// File: bench/sorted_array_search_engine_checker.sv
// Checker for the search engine: tracks the element store, predicts search results, compares.
module sorted_array_search_engine_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sase_pkg::SIZE_W-1:0]         i_cfg_wr_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [sase_pkg::FUNC_W-1:0]         i_func,
    input  logic [sase_pkg::ADDR_W-1:0]         i_elem_index,
    input  logic signed [sase_pkg::DATA_W-1:0]  i_data_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_found,
    input  logic [sase_pkg::ADDR_W-1:0]         i_match_index,
    input  logic [sase_pkg::CNT_W-1:0]          i_match_count,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sase_pkg::*;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] index;
        logic [CNT_W-1:0]  count;
    } t_search_result;

    logic signed [DATA_W-1:0] entries [DEPTH];
    logic [SIZE_W-1:0]        span;
    t_search_result           expected_results [$];
    int                       fail_total = 0;

    function automatic t_search_result run_search(input t_func op,
                                                  input logic signed [DATA_W-1:0] key);
        t_search_result res;
        int n, lo, hi, mid;
        res = '0;
        n = (span > DEPTH) ? DEPTH : int'(span);
        if (op == FUNC_BINARY) begin
            lo = 0;
            hi = n - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (entries[mid] == key) begin
                    res.found = 1'b1;
                    res.index = ADDR_W'(mid);
                    res.count = CNT_W'(1);
                    break;
                end
                if (key < entries[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                if (entries[i] == key) begin
                    res.count = res.count + 1'b1;
                    res.index = ADDR_W'(i);
                end
            end
            res.found = (res.count != '0);
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_search_result want;
        t_search_result got;
        if (!i_rst_n) begin
            span = '0;
            foreach (entries[i]) entries[i] = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en)
                span = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                case (t_func'(i_func)) inside
                    FUNC_WRITE: begin
                        entries[i_elem_index] = i_data_value;
                    end
                    FUNC_BINARY, FUNC_LINEAR: begin
                        expected_results.push_back(run_search(t_func'(i_func), i_data_value));
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_found, i_match_index, i_match_count};
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result with nothing pending: found=%0d idx=%0d cnt=%0d",
                                           got.found, got.index, got.count));
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found || got.index !== want.index ||
                        got.count !== want.count)
                        note_failure($sformatf(
                            "expected found=%0d idx=%0d cnt=%0d, got found=%0d idx=%0d cnt=%0d",
                            want.found, want.index, want.count,
                            got.found, got.index, got.count));
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: bench/sorted_array_search_engine_top_tb.sv
// Testbench top for the search engine: clock, reset, request and result traffic, verdict.
module sorted_array_search_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sase_pkg::*;

    localparam int MIN_WORD    = 32'sh8000_0000;
    localparam int MAX_WORD    = 32'sh7FFF_FFFF;
    localparam int TARGET_REQS = 1850;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_cfg_wr_en    = 1'b0;
    logic [SIZE_W-1:0]         i_cfg_wr_data  = '0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic [FUNC_W-1:0]         i_func         = '0;
    logic [ADDR_W-1:0]         i_elem_index   = '0;
    logic signed [DATA_W-1:0]  i_data_value   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic                      o_found;
    logic [ADDR_W-1:0]         o_match_index;
    logic [CNT_W-1:0]          o_match_count;

    int fail_count;
    int results_due;
    int requests_sent = 0;
    int quiet_cycles  = 0;
    int entry_vals [DEPTH];
    bit burst = 1'b0;

    always #1 i_clk = ~i_clk;

    sorted_array_search_engine_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_elem_index  (i_elem_index),
        .i_data_value  (i_data_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_match_index (o_match_index),
        .o_match_count (o_match_count)
    );

    sorted_array_search_engine_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_elem_index  (i_elem_index),
        .i_data_value  (i_data_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_found       (o_found),
        .i_match_index (o_match_index),
        .i_match_count (o_match_count),
        .o_fail_count  (fail_count),
        .o_pending     (results_due)
    );

    task automatic send_req(input t_func op, input logic [ADDR_W-1:0] idx, input int value);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= op;
        i_elem_index <= idx;
        i_data_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == FUNC_WRITE)
            entry_vals[idx] = value;
        if (op != FUNC_NONE)
            requests_sent++;
    endtask

    // drop valid, wait for every result, then let a trailing write or dropped request finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // key: mostly a stored value or a neighbor of one, sometimes fully random
    function automatic int pick_key(input int n);
        int k;
        int pick;
        k = $urandom_range(0, 3);
        if (n == 0 || k == 0)
            return $urandom;
        pick = entry_vals[$urandom_range(0, n - 1)];
        if (k == 3)
            pick = $urandom_range(0, 1) ? pick + 1 : pick - 1;
        return pick;
    endfunction

    initial begin : stimulus
        int phase;
        int sz;
        int n;
        int style;
        int r;
        int vals [$];
        foreach (entry_vals[i]) entry_vals[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // size zero straight out of reset, then a dropped func 3 request
        send_req(FUNC_BINARY, ADDR_W'(0), 0);
        send_req(FUNC_LINEAR, ADDR_W'(31), -1);
        send_req(FUNC_NONE, ADDR_W'(17), $urandom);
        send_req(FUNC_WRITE, ADDR_W'(0), MIN_WORD);
        send_req(FUNC_WRITE, ADDR_W'(1), -1);
        send_req(FUNC_WRITE, ADDR_W'(2), 0);
        send_req(FUNC_WRITE, ADDR_W'(3), MAX_WORD);
        send_req(FUNC_WRITE, ADDR_W'(31), 32'h5A5A_A5A5);
        settle();
        set_size(SIZE_W'(4));
        send_req(FUNC_BINARY, ADDR_W'(0), MIN_WORD);
        send_req(FUNC_BINARY, ADDR_W'(9), -1);
        send_req(FUNC_BINARY, ADDR_W'(0), 0);
        send_req(FUNC_BINARY, ADDR_W'(31), MAX_WORD);
        send_req(FUNC_BINARY, ADDR_W'(0), 5);
        send_req(FUNC_BINARY, ADDR_W'(0), -2);
        send_req(FUNC_LINEAR, ADDR_W'(0), -1);
        send_req(FUNC_LINEAR, ADDR_W'(0), MAX_WORD);
        send_req(FUNC_WRITE, ADDR_W'(2), -1);
        send_req(FUNC_LINEAR, ADDR_W'(0), -1);
        send_req(FUNC_BINARY, ADDR_W'(0), -1);

        phase = 0;
        while (requests_sent < TARGET_REQS) begin
            settle();
            case (phase)
                0: sz = 32;
                1: sz = 1;
                2: sz = 63;
                3: sz = 0;
                4: sz = 2;
                5: sz = 31;
                default: begin
                    r = $urandom_range(0, 15);
                    if (r == 0)
                        sz = 0;
                    else if (r == 1)
                        sz = 32;
                    else if (r == 2)
                        sz = $urandom_range(33, 63);
                    else
                        sz = $urandom_range(1, 12);
                end
            endcase
            set_size(SIZE_W'(sz));
            n = (sz > DEPTH) ? DEPTH : sz;
            burst = ($urandom_range(0, 2) == 0);

            // fill every entry a search can touch; sorted unless style 2
            style = $urandom_range(0, 3);
            vals.delete();
            for (int i = 0; i < n; i++) begin
                case (style)
                    1: vals.push_back(int'($urandom_range(0, 4)) - 2);
                    3: begin
                        r = $urandom_range(0, 2);
                        vals.push_back(r == 0 ? MIN_WORD : r == 1 ? MAX_WORD : int'($urandom));
                    end
                    default: vals.push_back($urandom);
                endcase
            end
            if (style != 2)
                vals.sort();
            for (int i = 0; i < n; i++)
                send_req(FUNC_WRITE, ADDR_W'(i), vals[i]);

            repeat ($urandom_range(60, 160)) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_req(FUNC_NONE, ADDR_W'($urandom_range(0, 31)), $urandom);
                else if (r == 1)
                    send_req(FUNC_WRITE, ADDR_W'($urandom_range(0, 31)), $urandom);
                else
                    send_req(t_func'(r < 11 ? FUNC_BINARY : FUNC_LINEAR),
                             ADDR_W'($urandom_range(0, 31)), pick_key(n));
            end
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side: random stall per result, calm stretches, one long hold to back up the engine
    initial begin : result_sink
        int w;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 32 == 0)
                calm = ($urandom_range(0, 2) == 0);
            w = calm ? 0 : $urandom_range(0, 7);
            if (taken == 150)
                w = 300;
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

// File: filelist.f
sv/sase_pkg.sv
sv/sase_ram.sv
sv/sorted_array_search_engine_top.sv
bench/sorted_array_search_engine_checker.sv
bench/sorted_array_search_engine_top_tb.sv
